// ===== design/lpht_pkg.sv =====
`default_nettype none

package lpht_pkg;

    localparam int KEY_W          = 16;
    localparam int STATUS_W       = 2;
    localparam int SLOT_W         = 4;
    localparam int DIV_CNT_W      = 2;
    localparam int TABLE_SIZE_DEF = 16;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_PROBE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    div_step;
        logic    probe_start;
        logic    advance;
        logic    we;
        logic    res_load;
        status_t res_code;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic empty;
        logic match;
        logic last;
        logic is_search;
    } sts_t;

endpackage

`default_nettype wire

// ===== design/lpht_ram.sv =====
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/lpht_ctrl.sv =====
`default_nettype none

module lpht_ctrl
    import lpht_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (sts.div_last) begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (sts.empty || sts.last || (sts.is_search && sts.match)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.res_code = STAT_OK;
        s_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_DIVIDE: begin
                cmd.div_step    = 1'b1;
                cmd.probe_start = sts.div_last;
            end
            S_PROBE: begin
                if (!sts.is_search) begin
                    if (sts.empty) begin
                        cmd.we       = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_code = STAT_OK;
                    end else if (sts.last) begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = STAT_FULL;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end else begin
                    if (sts.empty) begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = STAT_NOT_FOUND;
                    end else if (sts.match) begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = STAT_OK;
                    end else if (sts.last) begin
                        // A full wrap reports the home slot, which is one past the last probe.
                        cmd.res_load = 1'b1;
                        cmd.res_code = STAT_NOT_FOUND;
                        cmd.advance  = 1'b1;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            S_FINISH: begin
                cmd.out_load = !out_valid_reg || m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

    a_write_only_insert_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.we |-> (!sts.is_search && sts.empty))
        else $error("table write outside an insert into an empty slot");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while still held");

    a_clear_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR && sts.clr_last) |=> (state_reg == S_IDLE))
        else $error("clearing pass did not end in idle");

endmodule

`default_nettype wire

// ===== design/lpht_dp.sv =====
`default_nettype none

module lpht_dp
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_func,
    input  wire logic [KEY_W-1:0]    s_key,
    output logic      [STATUS_W-1:0] m_status,
    output logic      [SLOT_W-1:0]   m_slot,
    input  wire cmd_t                cmd,
    output sts_t                     sts
);

    localparam int AW        = $clog2(TABLE_SIZE);
    localparam int RW        = KEY_W + 1;
    localparam int DIV_SHIFT = KEY_W + AW;
    localparam int RECIP_W   = KEY_W + 1;
    localparam int PROD_W    = KEY_W + RECIP_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);
    localparam logic [AW:0]   SIZE_EXT = (AW + 1)'(TABLE_SIZE);
    localparam logic [KEY_W-1:0] SIZE_KEY = KEY_W'(TABLE_SIZE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / TABLE_SIZE);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(2);

    logic                 func_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [KEY_W-1:0]     quot_reg, quot_next;
    logic [AW:0]          rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [AW-1:0]        cnt_reg, cnt_next;
    status_t              res_status_reg;
    status_t              m_status_reg;
    logic [SLOT_W-1:0]    m_slot_reg;

    logic [PROD_W-1:0]    recip_prod;
    logic [KEY_W-1:0]     quot_times_size;
    logic [KEY_W-1:0]     rem_full;
    logic [AW:0]          rem_sub;
    logic [AW-1:0]        home;
    logic [AW-1:0]        addr_inc;
    logic [AW+SLOT_W-1:0] addr_ext;
    logic                 ram_we;
    logic [RW-1:0]        ram_wdata;
    logic [RW-1:0]        ram_rdata;

    // The reciprocal estimate of the quotient is exact or one short, so the
    // remainder lands below twice the table size and one subtract finishes it.
    assign recip_prod      = {{RECIP_W{1'b0}}, key_reg} * {{KEY_W{1'b0}}, RECIP};
    assign quot_next       = KEY_W'(recip_prod >> DIV_SHIFT);
    assign quot_times_size = quot_reg * SIZE_KEY;
    assign rem_full        = key_reg - quot_times_size;
    assign rem_next        = rem_full[AW:0];
    assign rem_sub         = rem_reg - SIZE_EXT;
    assign home            = (rem_reg >= SIZE_EXT) ? rem_sub[AW-1:0] : rem_reg[AW-1:0];

    assign addr_inc = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;

    always_comb begin
        div_cnt_next = div_cnt_reg;
        addr_next    = addr_reg;
        cnt_next     = cnt_reg;
        if (cmd.load) begin
            div_cnt_next = '0;
        end else if (cmd.div_step) begin
            div_cnt_next = div_cnt_reg + 1'b1;
        end
        if (cmd.clr_step || cmd.advance) begin
            addr_next = addr_inc;
        end else if (cmd.probe_start) begin
            addr_next = home;
        end
        if (cmd.probe_start) begin
            cnt_next = '0;
        end else if (cmd.advance) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else begin
            addr_reg <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        cnt_reg     <= cnt_next;
        if (cmd.load) begin
            func_reg <= s_func;
            key_reg  <= s_key;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_code;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= addr_ext[SLOT_W-1:0];
        end
    end

    assign addr_ext = {{SLOT_W{1'b0}}, addr_reg};

    // Each entry holds the occupancy bit above the stored key.
    assign ram_we    = cmd.clr_step || cmd.we;
    assign ram_wdata = cmd.we ? {1'b1, key_reg} : '0;

    lpht_ram #(
        .WIDTH(RW),
        .DEPTH(TABLE_SIZE)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(addr_reg),
        .wdata(ram_wdata),
        .raddr(addr_next),
        .rdata(ram_rdata)
    );

    assign sts.clr_last  = (addr_reg == LAST_IDX);
    assign sts.div_last  = (div_cnt_reg == DIV_LAST);
    assign sts.empty     = !ram_rdata[RW-1];
    assign sts.match     = (ram_rdata[KEY_W-1:0] == key_reg);
    assign sts.last      = (cnt_reg == LAST_IDX);
    assign sts.is_search = (func_reg == FUNC_SEARCH);

    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

    a_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        addr_reg <= LAST_IDX)
        else $error("probe address outside the table");

endmodule

`default_nettype wire

// ===== design/linear_probe_hash_table_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_func (0 insert, 1 search), s_key[15:0]
// m_        out        m_valid / m_ready  m_status[1:0], m_slot[3:0]
//
// An item is accepted, its key is reduced to its home slot in three steps
// (reciprocal multiply, multiply and subtract, one conditional subtract),
// then slots are probed in turn (1 to TABLE_SIZE, one table read per cycle),
// then the result moves to the output register when it is free or m_ready is high.
// After reset a clearing pass over every slot empties the table; no item is
// accepted meanwhile. A result waiting on m_ready does not block the next item
// until that item's own result is ready.

module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_func,
    input  wire logic [KEY_W-1:0]    s_key,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [STATUS_W-1:0] m_status,
    output logic      [SLOT_W-1:0]   m_slot
);

    cmd_t cmd;
    sts_t sts;

    lpht_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    lpht_dp #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_func  (s_func),
        .s_key   (s_key),
        .m_status(m_status),
        .m_slot  (m_slot),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

`default_nettype wire
